[rtl/bsif_pkg.sv]
// Shared types and constants for the byte-stuffed info framer.
// Used by bsif_front, bsif_queue, bsif_back and byte_stuffed_info_framer.
`timescale 1ns / 1ps
package bsif_pkg;

    localparam int CNT_W   = 11;
    localparam int LIMIT_W = 17;
    localparam int DEPTH   = 4;

    localparam int MAX_PAYLOAD_DEFAULT = 1024;

    localparam logic [7:0]       FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]       ESC_BYTE   = 8'h7D;
    localparam logic [7:0]       ESC_MASK   = 8'h20;
    localparam logic             SEQ_TOGGLE = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 11'd2047;

    localparam logic [7:0]       ADDR_RESET = 8'd3;
    localparam logic [CNT_W-1:0] MAXP_RESET = 11'd1024;

    // configuration register indexes
    localparam logic CFG_ADDR = 1'b0;
    localparam logic CFG_MAXP = 1'b1;

    // one classified input word, ready for expansion
    typedef struct packed {
        logic       hdr;
        logic       seq;
        logic [7:0] addr;
        logic       do_data;
        logic [7:0] data;
        logic       last;
        logic [7:0] check;
        logic       tl;
    } job_t;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

[rtl/bsif_front.sv]
// Front end: accepts payload words, tracks frame state, builds jobs.
// Depends on bsif_pkg.
`timescale 1ns / 1ps
module bsif_front #(
    parameter int MAX_PAYLOAD_BYTES = bsif_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    input  logic [7:0]                address_byte,
    input  logic [bsif_pkg::CNT_W-1:0] max_payload,
    output logic                      push,
    output bsif_pkg::job_t            job
);
    import bsif_pkg::*;

    localparam logic [LIMIT_W-1:0] MaxLimit = LIMIT_W'(MAX_PAYLOAD_BYTES);

    logic             seq_reg, seq_next;
    logic             in_frame_reg, in_frame_next;
    logic [7:0]       check_reg, check_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               was_new;
    logic [CNT_W-1:0]   cnt_base, cnt_new;
    logic [7:0]         chk_base, chk_new;
    logic [LIMIT_W-1:0] maxp_ext, limit;
    logic               tl;

    always_comb
    begin
        was_new  = !in_frame_reg;
        cnt_base = was_new ? '0 : count_reg;
        cnt_new  = (cnt_base < COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
        maxp_ext = LIMIT_W'(max_payload);
        limit    = (maxp_ext > MaxLimit) ? MaxLimit : maxp_ext;
        tl       = LIMIT_W'(cnt_new) > limit;
        chk_base = was_new ? '0 : check_reg;
        chk_new  = tl ? chk_base : (chk_base ^ data_byte);

        job.hdr     = was_new;
        job.seq     = seq_reg;
        job.addr    = address_byte;
        job.do_data = !tl;
        job.data    = data_byte;
        job.last    = last_byte;
        job.check   = chk_new;
        job.tl      = tl;

        push = accept && (was_new || !tl || last_byte);

        seq_next      = seq_reg;
        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                seq_next      = seq_reg ^ SEQ_TOGGLE;
                in_frame_next = 1'b0;
                check_next    = '0;
                count_next    = '0;
            end
            else
            begin
                in_frame_next = 1'b1;
                check_next    = chk_new;
                count_next    = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= 1'b0;
            in_frame_reg <= 1'b0;
            check_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            seq_reg      <= seq_next;
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
            count_reg    <= count_next;
        end
    end

endmodule

[rtl/bsif_queue.sv]
// Short job queue between the front end and the byte sequencer.
// Depends on bsif_pkg.
`timescale 1ns / 1ps
module bsif_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsif_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output bsif_pkg::job_t head,
    output logic           empty
);
    import bsif_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;

    always_comb
    begin
        full        = fill_reg == CNT_QW'(DEPTH);
        empty       = fill_reg == '0;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/bsif_back.sv]
// Back end: expands each job into the header, stuffed data, check and flag bytes it calls for.
// Drives the registered output word. Depends on bsif_pkg.
`timescale 1ns / 1ps
module bsif_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bsif_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_end,
    output logic           out_tl
);
    import bsif_pkg::*;

    typedef enum logic [3:0] {
        P_FLAG, P_ADDR, P_CTRL, P_HCHK, P_DATA, P_DESC, P_CHK, P_CESC, P_CLOSE
    } phase_t;

    logic       busy_reg, busy_next;
    phase_t     phase_reg, phase_next;
    job_t       job_reg, job_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       end_reg, end_next;
    logic       tl_reg, tl_next;

    job_t       cur;
    phase_t     ph, ph_after;
    logic [7:0] ctrl, b;
    logic       done, fe, emit;

    always_comb
    begin
        cur  = busy_reg ? job_reg : head;
        ctrl = {1'b0, cur.seq, 6'b0};
        if (busy_reg)
            ph = phase_reg;
        else if (head.hdr)
            ph = P_FLAG;
        else if (head.do_data)
            ph = P_DATA;
        else
            ph = P_CHK;

        b        = FLAG_BYTE;
        fe       = 1'b0;
        done     = 1'b0;
        ph_after = P_CLOSE;
        case (ph)
            P_FLAG:
            begin
                b        = FLAG_BYTE;
                ph_after = P_ADDR;
            end
            P_ADDR:
            begin
                b        = cur.addr;
                ph_after = P_CTRL;
            end
            P_CTRL:
            begin
                b        = ctrl;
                ph_after = P_HCHK;
            end
            P_HCHK:
            begin
                b        = cur.addr ^ ctrl;
                ph_after = cur.do_data ? P_DATA : P_CHK;
                done     = !cur.do_data && !cur.last;
            end
            P_DATA:
            begin
                if (needs_esc(cur.data))
                begin
                    b        = ESC_BYTE;
                    ph_after = P_DESC;
                end
                else
                begin
                    b        = cur.data;
                    ph_after = P_CHK;
                    done     = !cur.last;
                end
            end
            P_DESC:
            begin
                b        = cur.data ^ ESC_MASK;
                ph_after = P_CHK;
                done     = !cur.last;
            end
            P_CHK:
            begin
                if (needs_esc(cur.check))
                begin
                    b        = ESC_BYTE;
                    ph_after = P_CESC;
                end
                else
                begin
                    b        = cur.check;
                    ph_after = P_CLOSE;
                end
            end
            P_CESC:
            begin
                b        = cur.check ^ ESC_MASK;
                ph_after = P_CLOSE;
            end
            P_CLOSE:
            begin
                b    = FLAG_BYTE;
                fe   = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                b    = FLAG_BYTE;
                done = 1'b1;
            end
        endcase

        emit = (busy_reg || !empty) && (!valid_reg || out_ready);
        pop  = emit && !busy_reg;

        busy_next  = busy_reg;
        phase_next = phase_reg;
        job_next   = job_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        tl_next    = tl_reg;
        if (emit)
        begin
            busy_next  = !done;
            phase_next = ph_after;
            job_next   = cur;
            valid_next = 1'b1;
            byte_next  = b;
            last_next  = done;
            end_next   = fe;
            tl_next    = cur.tl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= P_FLAG;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        end_reg  <= end_next;
        tl_reg   <= tl_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_end   = end_reg;
    assign out_tl    = tl_reg;

endmodule

[rtl/byte_stuffed_info_framer.sv]
// Jobs pass through the queue; each line byte is registered in the back end's output stage.
// Throughput: one line byte per cycle while m_axis_tready holds and a job waits; a word
// becomes 0 to 9 line bytes (header 4, data 1-2, check 1-2, flag 1) in the back sequencer.
// Input is taken every cycle while the four-entry job queue has room.
// Reset (rst_n low, async) clears frame state, queue and output; registers reload defaults.
// Top level: config registers, bsif_front, bsif_queue, bsif_back. Depends on bsif_pkg.
`timescale 1ns / 1ps
module byte_stuffed_info_framer #(
    parameter int MAX_PAYLOAD_BYTES = bsif_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
    input  logic                       s_axis_tlast,  // last_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] line_byte
    output logic                       m_axis_tlast,  // run_last
    output logic [1:0]                 m_axis_tuser,  // [0] frame_end, [1] too_long
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bsif_pkg::CNT_W-1:0] cfg_data
);
    import bsif_pkg::*;

    logic [7:0]       address_reg;
    logic [CNT_W-1:0] max_payload_reg;

    logic accept, push, full, pop, empty;
    logic out_end, out_tl;
    job_t fjob, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg     <= ADDR_RESET;
            max_payload_reg <= MAXP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADDR: address_reg     <= cfg_data[7:0];
                CFG_MAXP: max_payload_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    bsif_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_axis_tdata),
        .last_byte    (s_axis_tlast),
        .address_byte (address_reg),
        .max_payload  (max_payload_reg),
        .push         (push),
        .job          (fjob)
    );

    bsif_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (fjob),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    bsif_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_end   (out_end),
        .out_tl    (out_tl)
    );

    assign m_axis_tuser = {out_tl, out_end};

endmodule
